### hw/rtl/mer_pkg.sv
// shared types and constants for the midpoint ellipse rasterizer
package mer_pkg;

    localparam int AXIS_BITS_DEF = 10;
    localparam int PIX_W         = 13;
    localparam int HALF_W        = 11;
    localparam int CENTER_W      = 12;
    localparam int CFG_IDX_W     = 1;

    localparam logic [HALF_W-1:0] HALF_WIDTH_RST  = 11'd320;
    localparam logic [HALF_W-1:0] HALF_HEIGHT_RST = 11'd240;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 1'b1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [1:0] BEAT_LAST = 2'd3;

    // operand selection and destination of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,
        MUL_BB,
        MUL_AB,
        MUL_BX,
        MUL_AY,
        MUL_T1,
        MUL_T2,
        MUL_P1,
        MUL_P2
    } mul_op_t;

    typedef struct packed {
        logic      load_start;
        mul_op_t   mul_op;
        logic      region_chk;
        logic      emit;
        logic [1:0] beat;
        logic      decide;
    } dp_cmd_t;

endpackage

### hw/rtl/mer_ctrl.sv
// sequencing state machine for the ellipse rasterizer
module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             op,
    input  logic             out_stall,
    input  logic             fig_active,
    output logic             in_stall,
    output logic             out_valid,
    output mer_pkg::dp_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SET_AA,
        ST_SET_BB,
        ST_SET_AB,
        ST_MUL_BX,
        ST_MUL_AY,
        ST_REGION,
        ST_EMIT,
        ST_MUL_T1,
        ST_MUL_T2,
        ST_MUL_P1,
        ST_MUL_P2,
        ST_DECIDE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] beat_reg;
    logic [1:0] beat_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_op     = mer_pkg::MUL_NONE;
        cmd.beat       = beat_reg;
        state_next     = state_reg;
        beat_next      = beat_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == mer_pkg::OP_START)
                    begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_SET_AA;
                    end
                    else if (fig_active)
                    begin
                        state_next = ST_MUL_BX;
                    end
                end
            end
            ST_SET_AA:
            begin
                cmd.mul_op = mer_pkg::MUL_AA;
                state_next = ST_SET_BB;
            end
            ST_SET_BB:
            begin
                cmd.mul_op = mer_pkg::MUL_BB;
                state_next = ST_SET_AB;
            end
            ST_SET_AB:
            begin
                cmd.mul_op = mer_pkg::MUL_AB;
                state_next = ST_IDLE;
            end
            ST_MUL_BX:
            begin
                cmd.mul_op = mer_pkg::MUL_BX;
                state_next = ST_MUL_AY;
            end
            ST_MUL_AY:
            begin
                cmd.mul_op = mer_pkg::MUL_AY;
                state_next = ST_REGION;
            end
            ST_REGION:
            begin
                cmd.region_chk = 1'b1;
                beat_next      = 2'd0;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    beat_next      = beat_reg + 2'd1;
                    if (beat_reg == mer_pkg::BEAT_LAST)
                    begin
                        state_next = ST_MUL_T1;
                    end
                end
            end
            ST_MUL_T1:
            begin
                cmd.mul_op = mer_pkg::MUL_T1;
                state_next = ST_MUL_T2;
            end
            ST_MUL_T2:
            begin
                cmd.mul_op = mer_pkg::MUL_T2;
                state_next = ST_MUL_P1;
            end
            ST_MUL_P1:
            begin
                cmd.mul_op = mer_pkg::MUL_P1;
                state_next = ST_MUL_P2;
            end
            ST_MUL_P2:
            begin
                cmd.mul_op = mer_pkg::MUL_P2;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            beat_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/mer_datapath.sv
// figure registers, shared multiplier, midpoint decision and pixel output register
module mer_datapath #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mer_pkg::dp_cmd_t                    cmd,
    input  logic signed [mer_pkg::CENTER_W-1:0] center_x,
    input  logic signed [mer_pkg::CENTER_W-1:0] center_y,
    input  logic [AXIS_BITS-1:0]                semi_a,
    input  logic [AXIS_BITS-1:0]                semi_b,
    input  logic [mer_pkg::HALF_W-1:0]          half_width,
    input  logic [mer_pkg::HALF_W-1:0]          half_height,
    output logic                                fig_active,
    output logic signed [mer_pkg::PIX_W-1:0]    pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]    pixel_y,
    output logic                                last,
    output logic                                done_res
);

    localparam int N   = AXIS_BITS;
    localparam int XW  = N + 1;
    localparam int YW  = N + 2;
    localparam int TW  = N + 2;
    localparam int SQW = 2 * N;
    localparam int TQW = 2 * N + 4;
    localparam int MW  = 2 * N + 4;
    localparam int PW  = 2 * MW;
    localparam int CW  = 3 * N + 1;
    localparam int RW  = 4 * N + 2;
    localparam int QW  = 4 * N + 4;
    localparam int LW  = 4 * N + 7;
    localparam int PXW = mer_pkg::PIX_W;
    localparam int SW  = (YW + 1 > PXW) ? YW + 1 : PXW;

    logic [N-1:0]                        a_reg;
    logic [N-1:0]                        b_reg;
    logic signed [mer_pkg::CENTER_W-1:0] cx_reg;
    logic signed [mer_pkg::CENTER_W-1:0] cy_reg;
    logic [XW-1:0]                       x_reg;
    logic [XW-1:0]                       x_next;
    logic signed [YW-1:0]                y_reg;
    logic signed [YW-1:0]                y_next;
    logic                                region_reg;
    logic                                active_reg;
    logic [SQW-1:0]                      aa_reg;
    logic [SQW-1:0]                      bb_reg;
    logic [RW-1:0]                       ab4_reg;
    logic [CW-1:0]                       bx_reg;
    logic [CW-1:0]                       ay_reg;
    logic [TQW-1:0]                      t1sq_reg;
    logic [TQW-1:0]                      t2sq_reg;
    logic [QW-1:0]                       p1_reg;
    logic [QW-1:0]                       p2_reg;

    logic [MW-1:0]  mul_a;
    logic [MW-1:0]  mul_b;
    logic [PW-1:0]  prod;
    logic [TW-1:0]  x_t;
    logic [TW-1:0]  y_t;
    logic [TW-1:0]  t1;
    logic [TW-1:0]  t2;
    logic           y_zero;
    logic           fin;
    logic [LW-1:0]  lhs;
    logic [LW-1:0]  rhs;

    logic [SW-1:0]  x_w;
    logic [SW-1:0]  y_w;
    logic [PXW-1:0] col_base;
    logic [PXW-1:0] row_base;
    logic [PXW-1:0] col0;
    logic [PXW-1:0] col1;
    logic [PXW-1:0] row0;
    logic [PXW-1:0] row1;
    logic [PXW-1:0] px_sel;
    logic [PXW-1:0] py_sel;

    assign fig_active = active_reg;
    assign y_zero     = (y_reg == '0);
    assign fin        = region_reg && y_zero;

    // midpoint terms, y is never negative while a figure is active
    assign x_t = TW'(x_reg);
    assign y_t = TW'(y_reg[N:0]);
    always_comb
    begin
        if (region_reg)
        begin
            t1 = (x_t << 1) + TW'(1);
            t2 = y_zero ? TW'(1) : y_t - TW'(1);
        end
        else
        begin
            t1 = x_t + TW'(1);
            t2 = y_zero ? TW'(1) : (y_t << 1) - TW'(1);
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            mer_pkg::MUL_AA:
            begin
                mul_a = MW'(a_reg);
                mul_b = MW'(a_reg);
            end
            mer_pkg::MUL_BB:
            begin
                mul_a = MW'(b_reg);
                mul_b = MW'(b_reg);
            end
            mer_pkg::MUL_AB:
            begin
                mul_a = MW'(aa_reg);
                mul_b = MW'(bb_reg);
            end
            mer_pkg::MUL_BX:
            begin
                mul_a = MW'(bb_reg);
                mul_b = MW'(x_reg);
            end
            mer_pkg::MUL_AY:
            begin
                mul_a = MW'(aa_reg);
                mul_b = MW'(y_reg[N:0]);
            end
            mer_pkg::MUL_T1:
            begin
                mul_a = MW'(t1);
                mul_b = MW'(t1);
            end
            mer_pkg::MUL_T2:
            begin
                mul_a = MW'(t2);
                mul_b = MW'(t2);
            end
            mer_pkg::MUL_P1:
            begin
                mul_a = MW'(t1sq_reg);
                mul_b = MW'(bb_reg);
            end
            mer_pkg::MUL_P2:
            begin
                mul_a = MW'(t2sq_reg);
                mul_b = MW'(aa_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // decision scaled by four: the factor of four sits on the x term in region one
    always_comb
    begin
        if (region_reg)
        begin
            lhs = LW'(p1_reg) + (LW'(p2_reg) << 2);
        end
        else
        begin
            lhs = (LW'(p1_reg) << 2) + LW'(p2_reg);
        end
        rhs = LW'(ab4_reg);
        if (region_reg)
        begin
            x_next = (lhs <= rhs) ? x_reg + XW'(1) : x_reg;
            y_next = y_reg - YW'(1);
        end
        else
        begin
            x_next = x_reg + XW'(1);
            y_next = (lhs >= rhs) ? y_reg - YW'(1) : y_reg;
        end
    end

    // screen coordinates, wrapped to the pixel width
    assign x_w      = SW'(x_reg);
    assign y_w      = SW'(y_reg);
    assign col_base = PXW'(half_width) + PXW'(cx_reg);
    assign row_base = PXW'(half_height) - PXW'(cy_reg);
    assign col0     = col_base + x_w[PXW-1:0];
    assign col1     = col_base - x_w[PXW-1:0];
    assign row0     = row_base - y_w[PXW-1:0];
    assign row1     = row_base + y_w[PXW-1:0];

    always_comb
    begin
        case (cmd.beat)
            2'd0:
            begin
                px_sel = col0;
                py_sel = row0;
            end
            2'd1:
            begin
                px_sel = col1;
                py_sel = row0;
            end
            2'd2:
            begin
                px_sel = col1;
                py_sel = row1;
            end
            default:
            begin
                px_sel = col0;
                py_sel = row1;
            end
        endcase
    end

    // figure control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                region_reg <= 1'b0;
                active_reg <= 1'b1;
            end
            else
            begin
                if (cmd.region_chk && !region_reg && !(bx_reg < ay_reg))
                begin
                    region_reg <= 1'b1;
                end
                if (cmd.decide && fin)
                begin
                    active_reg <= 1'b0;
                end
            end
        end
    end

    // figure payload and products
    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            a_reg  <= semi_a;
            b_reg  <= semi_b;
            cx_reg <= center_x;
            cy_reg <= center_y;
            x_reg  <= '0;
            y_reg  <= YW'(semi_b);
        end
        else if (cmd.decide)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
        case (cmd.mul_op)
            mer_pkg::MUL_AA: aa_reg   <= prod[SQW-1:0];
            mer_pkg::MUL_BB: bb_reg   <= prod[SQW-1:0];
            mer_pkg::MUL_AB: ab4_reg  <= {prod[RW-3:0], 2'b00};
            mer_pkg::MUL_BX: bx_reg   <= prod[CW-1:0];
            mer_pkg::MUL_AY: ay_reg   <= prod[CW-1:0];
            mer_pkg::MUL_T1: t1sq_reg <= prod[TQW-1:0];
            mer_pkg::MUL_T2: t2sq_reg <= prod[TQW-1:0];
            mer_pkg::MUL_P1: p1_reg   <= prod[QW-1:0];
            mer_pkg::MUL_P2: p2_reg   <= prod[QW-1:0];
            default:
            begin
            end
        endcase
        if (cmd.emit)
        begin
            pixel_x  <= px_sel;
            pixel_y  <= py_sel;
            last     <= (cmd.beat == mer_pkg::BEAT_LAST);
            done_res <= (cmd.beat == mer_pkg::BEAT_LAST) && fin;
        end
    end

endmodule

### hw/rtl/midpoint_ellipse_raster.sv
// top level of the midpoint ellipse rasterizer
// usage:
//   input channel (in_valid / in_stall) carries one request: op selects start or step.
//   a start request loads centre and semi-axes and puts the point at (0, semi_b);
//   it produces no pixels and holds in_stall high while a*a, b*b
//   and 4*a*a*b*b are formed on the shared multiplier.
//   a step request on an active figure produces four mirrored pixels on the
//   output channel (out_valid / out_stall), last set on the fourth, done_res set
//   on the fourth pixel of the final point of the figure.
//   a step with no active figure is taken and gives nothing.
//   a step holds the block while it works through two multiplies on the single
//   shared multiplier, the region check, the four output beats, four more
//   multiplies and the decision, six multiplies in all.
//   out_stall holds the output register; the step simply waits in its emit
//   state, and in_stall stays high until the step is fully finished.
//   reset clears the figure (no active figure), the sequencer and out_valid;
//   half_width and half_height return to 320 and 240.
//   configuration writes (cfg_we, cfg_idx, cfg_data) take effect at once and
//   are expected only while the block is idle.
module midpoint_ellipse_raster #(
    parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [mer_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [mer_pkg::HALF_W-1:0]           cfg_data,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic signed [mer_pkg::CENTER_W-1:0]  center_x,
    input  logic signed [mer_pkg::CENTER_W-1:0]  center_y,
    input  logic [AXIS_BITS-1:0]                 semi_a,
    input  logic [AXIS_BITS-1:0]                 semi_b,
    // pixel channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mer_pkg::PIX_W-1:0]     pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]     pixel_y,
    output logic                                 last,
    output logic                                 done_res
);

    logic [mer_pkg::HALF_W-1:0] half_width_reg;
    logic [mer_pkg::HALF_W-1:0] half_height_reg;
    mer_pkg::dp_cmd_t           cmd;
    logic                       fig_active;

    // window origin registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= mer_pkg::HALF_WIDTH_RST;
            half_height_reg <= mer_pkg::HALF_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                mer_pkg::REG_HALF_WIDTH:  half_width_reg  <= cfg_data;
                mer_pkg::REG_HALF_HEIGHT: half_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: accepts requests, steps the multiplier, paces the pixel beats
    mer_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .op         (op),
        .out_stall  (out_stall),
        .fig_active (fig_active),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .cmd        (cmd)
    );

    // figure state, decision arithmetic and output pixel register
    mer_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .center_x    (center_x),
        .center_y    (center_y),
        .semi_a      (semi_a),
        .semi_b      (semi_b),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .fig_active  (fig_active),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last        (last),
        .done_res    (done_res)
    );

    // end of figure only ever marks the fourth pixel of a step
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> last)
        else $error("done_res without last");

    // a start request always runs the setup multiplies before the next request
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == mer_pkg::OP_START) |=> in_stall)
        else $error("start request not followed by setup");

    // pixels appear only while a step is being worked
    a_pixel_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("pixel emitted outside a step");

    // a new figure never starts pixels in the same cycle as the start request
    a_no_emit_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_start |-> !cmd.emit && !cmd.decide)
        else $error("start overlaps step work");

endmodule
